/* rtl/skvt_pkg.sv */
package skvt_pkg;

    localparam int KeyW = 32;
    localparam int ValW = 32;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_LOOKUP = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_LIST   = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]             action;
        logic signed [KeyW-1:0] key;
        logic [ValW-1:0]        value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic signed [KeyW-1:0] out_key;
        logic [ValW-1:0]        out_value;
        logic                   last;
    } t_out_item;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_UPD,
        CELL_ROT
    } t_cell_op;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        t_cell_op               op;
        logic                   cmp;
        logic signed [KeyW-1:0] key;
        logic [ValW-1:0]        value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LIST
    } t_state;

endpackage

/* rtl/skvt_cell.sv */
module skvt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                           i_clk,
    input  skvt_pkg::t_cell_ctl            i_ctl,
    input  logic [CW-1:0]                  i_count,
    input  logic signed [skvt_pkg::KeyW-1:0] i_left_key,
    input  logic [skvt_pkg::ValW-1:0]      i_left_value,
    input  logic                           i_left_lt,
    input  logic signed [skvt_pkg::KeyW-1:0] i_right_key,
    input  logic [skvt_pkg::ValW-1:0]      i_right_value,
    output logic signed [skvt_pkg::KeyW-1:0] o_key,
    output logic [skvt_pkg::ValW-1:0]      o_value,
    output logic                           o_lt,
    output logic                           o_first
);
    import skvt_pkg::*;

    logic signed [KeyW-1:0] r_key, n_key;
    logic [ValW-1:0]        r_value, n_value;
    logic                   r_lt, r_eq;
    logic                   occ, tail;

    assign occ  = CW'(IDX) < i_count;
    assign tail = i_count == CW'(IDX + 1);

    // sorted order: first match is an equal cell whose left neighbor is smaller
    assign o_first = r_eq & i_left_lt;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        case (i_ctl.op)
            CELL_INS: begin
                if (!r_lt) begin
                    if (i_left_lt) begin
                        n_key   = i_ctl.key;
                        n_value = i_ctl.value;
                    end else begin
                        n_key   = i_left_key;
                        n_value = i_left_value;
                    end
                end
            end
            CELL_DEL: begin
                if (!r_lt) begin
                    n_key   = i_right_key;
                    n_value = i_right_value;
                end
            end
            CELL_UPD: begin
                if (o_first) begin
                    n_value = i_ctl.value;
                end
            end
            CELL_ROT: begin
                // tail of the occupied run takes the head entry
                if (tail) begin
                    n_key   = i_ctl.key;
                    n_value = i_ctl.value;
                end else begin
                    n_key   = i_right_key;
                    n_value = i_right_value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        if (i_ctl.cmp) begin
            r_lt <= occ && (r_key < i_ctl.key);
            r_eq <= occ && (r_key == i_ctl.key);
        end
    end

endmodule

/* rtl/sorted_key_value_table_core.sv */
// Sorted key/value table held in a chain of CAPACITY cells, kept in ascending
// signed key order with duplicates allowed; a new entry goes in front of equal
// keys. Insert, lookup, update and remove compare the key in every cell at once
// on acceptance; then, once the output is free, the chain shifts and the result
// register loads. A list transaction emits the N stored entries in order: the
// chain rotates one position toward the head per emitted entry, so one entry
// leaves per cycle while the output is not stalled, and the chain is back in
// order after the last one.
module sorted_key_value_table_core #(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  skvt_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output skvt_pkg::t_out_item o_out
);
    import skvt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state    r_state, n_state;
    t_in_item  r_req;
    t_out_item r_out, n_out;
    logic      r_ov;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic      ld_out;
    t_cell_ctl ctl;

    logic signed [KeyW-1:0] w_key   [CAPACITY];
    logic [ValW-1:0]        w_value [CAPACITY];
    logic [CAPACITY-1:0]    w_lt, w_first;

    logic                   found, full, out_free, accept, list_last;
    logic signed [KeyW-1:0] f_key;
    logic [ValW-1:0]        f_value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [KeyW-1:0] lkey, rkey;
            logic [ValW-1:0]        lval, rval;
            logic                   llt;
            if (g == 0) begin : g_head
                assign lkey = '0;
                assign lval = '0;
                assign llt  = 1'b1;
            end else begin : g_mid
                assign lkey = w_key[g-1];
                assign lval = w_value[g-1];
                assign llt  = w_lt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign rkey = '0;
                assign rval = '0;
            end else begin : g_body
                assign rkey = w_key[g+1];
                assign rval = w_value[g+1];
            end
            skvt_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_count      (r_count),
                .i_left_key   (lkey),
                .i_left_value (lval),
                .i_left_lt    (llt),
                .i_right_key  (rkey),
                .i_right_value(rval),
                .o_key        (w_key[g]),
                .o_value      (w_value[g]),
                .o_lt         (w_lt[g]),
                .o_first      (w_first[g])
            );
        end
    endgenerate

    // at most one cell flags first match, so an OR picks its entry
    always_comb begin
        f_key   = '0;
        f_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            f_key   = f_key   | (w_key[i]   & {KeyW{w_first[i]}});
            f_value = f_value | (w_value[i] & {ValW{w_first[i]}});
        end
    end

    assign found     = |w_first;
    assign full      = r_count == CW'(CAPACITY);
    assign out_free  = !r_ov || !i_out_stall;
    assign accept    = i_in_valid && !o_in_stall;
    assign list_last = r_idx == r_count - CW'(1);

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (r_req.action == ACT_LIST && r_count != '0) n_state = ST_LIST;
                    else n_state = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (out_free && list_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and chain control
    always_comb begin
        ctl       = '{op: CELL_HOLD, cmp: 1'b0, key: r_req.key, value: r_req.value};
        ld_out    = 1'b0;
        n_out     = r_out;
        n_count   = r_count;
        n_idx     = r_idx;
        case (r_state)
            ST_IDLE: begin
                ctl.cmp = 1'b1;
                ctl.key = i_in.key;
            end
            ST_EXEC: begin
                n_idx = '0;
                if (out_free) begin
                    case (r_req.action)
                        ACT_INSERT: begin
                            ld_out = 1'b1;
                            if (full) begin
                                n_out = '{STS_FULL, r_req.key, '0, 1'b1};
                            end else begin
                                ctl.op  = CELL_INS;
                                n_count = r_count + CW'(1);
                                n_out   = '{STS_OK, r_req.key, r_req.value, 1'b1};
                            end
                        end
                        ACT_LOOKUP, ACT_UPDATE, ACT_REMOVE: begin
                            ld_out = 1'b1;
                            if (!found) begin
                                n_out = '{STS_NOT_FOUND, r_req.key, '0, 1'b1};
                            end else if (r_req.action == ACT_UPDATE) begin
                                ctl.op = CELL_UPD;
                                n_out  = '{STS_OK, f_key, r_req.value, 1'b1};
                            end else if (r_req.action == ACT_REMOVE) begin
                                ctl.op  = CELL_DEL;
                                n_count = r_count - CW'(1);
                                n_out   = '{STS_OK, f_key, f_value, 1'b1};
                            end else begin
                                n_out = '{STS_OK, f_key, f_value, 1'b1};
                            end
                        end
                        ACT_LIST: begin
                            if (r_count == '0) begin
                                ld_out = 1'b1;
                                n_out  = '{STS_EMPTY, '0, '0, 1'b1};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    ld_out    = 1'b1;
                    n_out     = '{STS_OK, w_key[0], w_value[0], list_last};
                    ctl.op    = CELL_ROT;
                    ctl.key   = w_key[0];
                    ctl.value = w_value[0];
                    n_idx     = r_idx + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (ld_out) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_in;
        if (ld_out) r_out <= n_out;
    end

endmodule

/* rtl/skvt_checker.sv */
module skvt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input skvt_pkg::t_out_item i_out
);
    import skvt_pkg::*;

    // a held result does not change under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out))
        else $error("result changed while stalled");

    // one transaction at a time: acceptance closes the input for the next cycle
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input taken during execution");

    // any error or empty status is a single-result answer
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.status != STS_OK |-> i_out.last)
        else $error("non-ok status without last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.status == STS_EMPTY |-> i_out.out_key == '0 && i_out.out_value == '0)
        else $error("empty status carries data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("not idle after reset");

endmodule

bind sorted_key_value_table_core skvt_checker u_skvt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_out      (o_out)
);

/* verif/skvt_result_checker.sv */
`timescale 1ns / 1ps

module skvt_result_checker #(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  skvt_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  skvt_pkg::t_out_item i_out,
    output int                  o_fail_count,
    output int                  o_pending
);
    import skvt_pkg::*;

    localparam int ReportLimit = 10;

    logic signed [KeyW-1:0] entry_key [CAPACITY];
    logic [ValW-1:0]        entry_val [CAPACITY];
    int                     entry_total = 0;
    t_out_item              expected_results [$];
    int                     fails = 0;

    // Mirror of the sorted table: applies one transaction and queues its results.
    function automatic void apply_action(input t_in_item req);
        t_out_item res;
        int        pos;
        int        i;
        res.status    = STS_OK;
        res.out_key   = req.key;
        res.out_value = '0;
        res.last      = 1'b1;
        case (req.action)
            ACT_INSERT: begin
                if (entry_total >= CAPACITY) begin
                    res.status = STS_FULL;
                end else begin
                    // new entry lands in front of any equal keys
                    pos = 0;
                    while (pos < entry_total && $signed(entry_key[pos]) < $signed(req.key))
                        pos++;
                    for (i = entry_total; i > pos; i--) begin
                        entry_key[i] = entry_key[i-1];
                        entry_val[i] = entry_val[i-1];
                    end
                    entry_key[pos] = req.key;
                    entry_val[pos] = req.value;
                    entry_total++;
                    res.out_value = req.value;
                end
                expected_results.push_back(res);
            end
            ACT_LOOKUP, ACT_UPDATE, ACT_REMOVE: begin
                pos = 0;
                while (pos < entry_total && entry_key[pos] != req.key)
                    pos++;
                if (pos == entry_total) begin
                    res.status = STS_NOT_FOUND;
                end else begin
                    if (req.action == ACT_UPDATE)
                        entry_val[pos] = req.value;
                    res.out_key   = entry_key[pos];
                    res.out_value = entry_val[pos];
                    if (req.action == ACT_REMOVE) begin
                        for (i = pos; i + 1 < entry_total; i++) begin
                            entry_key[i] = entry_key[i+1];
                            entry_val[i] = entry_val[i+1];
                        end
                        entry_total--;
                    end
                end
                expected_results.push_back(res);
            end
            ACT_LIST: begin
                if (entry_total == 0) begin
                    res.status  = STS_EMPTY;
                    res.out_key = '0;
                    expected_results.push_back(res);
                end else begin
                    for (i = 0; i < entry_total; i++) begin
                        res.out_key   = entry_key[i];
                        res.out_value = entry_val[i];
                        res.last      = (i == entry_total - 1);
                        expected_results.push_back(res);
                    end
                end
            end
            default: ;  // unused codes: no result, no change
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                apply_action(i_in);
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (fails < ReportLimit)
                        $display("%0t: unexpected transaction sts=%0d key=%0d val=%h last=%b",
                                 $time, i_out.status, $signed(i_out.out_key),
                                 i_out.out_value, i_out.last);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_out.status || want.out_key !== i_out.out_key ||
                        want.out_value !== i_out.out_value || want.last !== i_out.last) begin
                        if (fails < ReportLimit)
                            $display("%0t: mismatch exp sts=%0d key=%0d val=%h last=%b, got sts=%0d key=%0d val=%h last=%b",
                                     $time, want.status, $signed(want.out_key),
                                     want.out_value, want.last, i_out.status,
                                     $signed(i_out.out_key), i_out.out_value, i_out.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

/* verif/tb_sorted_key_value_table_core.sv */
`timescale 1ns / 1ps

module tb_sorted_key_value_table_core;
    import skvt_pkg::*;

    localparam int         TableDepth  = 32;
    localparam int         RandomItems = 460;
    localparam int         QuietTail   = 60;
    localparam int         HoldAt      = 120;
    localparam int         LongHold    = 400;
    localparam int         SettleAt    = 300;
    localparam int         ModeLength  = 40;
    localparam int         DrainLimit  = 100000;
    localparam int         TailCycles  = 64;
    localparam int         PoolSize    = 12;
    localparam logic [2:0] ActCodeMax  = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        quiet = 1'b0;
    bit        hold_req = 1'b0;

    logic signed [KeyW-1:0] key_pool [PoolSize];

    sorted_key_value_table_core #(
        .CAPACITY(TableDepth)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    skvt_result_checker #(
        .CAPACITY(TableDepth)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly keys from a small pool so hits and duplicates are common
    function automatic logic signed [KeyW-1:0] pick_key();
        if ($urandom_range(0, 6) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, PoolSize - 1)];
    endfunction

    task automatic issue(input logic [2:0] act, input logic signed [KeyW-1:0] k,
                         input logic [ValW-1:0] v);
        t_in_item req;
        req.action = act;
        req.key    = k;
        req.value  = v;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_item  <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // output side back-pressure
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (LongHold) @(posedge clk);
                out_stall <= 1'b0;
                hold_req  <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int         counted;
        int         mode;
        int         left_in_mode;
        int         roll;
        int         ins_w;
        int         rem_w;
        int         code;
        int         waited;
        logic [2:0] act;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_item  <= '0;

        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (int p = 4; p < 8; p++)
            key_pool[p] = $urandom;
        for (int p = 8; p < PoolSize; p++)
            key_pool[p] = int'($urandom_range(0, 64)) - 32;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty-table cases
        issue(ACT_LIST,   '0, '0);
        issue(ACT_LOOKUP, 32'sd5, '0);
        issue(ACT_UPDATE, 32'sd5, 32'hFFFF_FFFF);
        issue(ACT_REMOVE, 32'sd5, '0);
        // extremes, then a duplicate that must sit in front of the older 0
        issue(ACT_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        issue(ACT_INSERT, 32'sh8000_0000, 32'h0000_0000);
        issue(ACT_INSERT, '0, 32'hA5A5_A5A5);
        issue(ACT_INSERT, -32'sd1, 32'h5A5A_5A5A);
        issue(ACT_INSERT, '0, 32'h0000_0001);
        issue(ACT_LOOKUP, '0, '0);
        issue(ACT_UPDATE, '0, 32'h1234_5678);
        issue(ACT_LIST,   '0, '0);
        issue(ACT_REMOVE, '0, '0);
        issue(ACT_LOOKUP, '0, '0);
        for (code = ACT_LIST + 1; code <= ActCodeMax; code++)
            issue(3'(code), pick_key(), $urandom);
        issue(ACT_REMOVE, 32'sh8000_0000, '0);
        issue(ACT_REMOVE, 32'sh7FFF_FFFF, '0);
        issue(ACT_LOOKUP, 32'sd12345, '0);
        issue(ACT_LIST,   '0, '0);

        // random part in blocks that fill, churn or drain the table; starts filling
        counted      = 0;
        mode         = 0;
        left_in_mode = ModeLength;
        while (counted < RandomItems) begin
            case (mode)
                0: begin
                    ins_w = 70;
                    rem_w = 7;
                end
                1: begin
                    ins_w = 30;
                    rem_w = 27;
                end
                default: begin
                    ins_w = 10;
                    rem_w = 60;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                act = 3'($urandom_range(ACT_LIST + 1, ActCodeMax));
            end else if (roll < 3 + ins_w) begin
                act = ACT_INSERT;
            end else if (roll < 3 + ins_w + rem_w) begin
                act = ACT_REMOVE;
            end else begin
                roll = $urandom_range(0, 9);
                act  = (roll < 4) ? ACT_LOOKUP : (roll < 8) ? ACT_UPDATE : ACT_LIST;
            end
            issue(act, pick_key(), $urandom);
            if (act <= ACT_LIST) begin
                counted++;
                left_in_mode--;
                if (left_in_mode == 0) begin
                    mode         = $urandom_range(0, 2);
                    left_in_mode = ModeLength;
                end
                if (counted == HoldAt)
                    hold_req <= 1'b1;
                if (counted == RandomItems - QuietTail)
                    quiet <= 1'b1;
                if (counted == SettleAt) begin
                    // let the table go fully idle before carrying on
                    in_valid <= 1'b0;
                    do @(posedge clk); while (pending != 0);
                end
            end
        end
        in_valid <= 1'b0;

        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending != 0 && waited < DrainLimit);
        repeat (TailCycles) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table_core.sv
rtl/skvt_checker.sv
verif/skvt_result_checker.sv
verif/tb_sorted_key_value_table_core.sv
